>>> hdl/pbt_pkg.sv
// Shared types and constants for the port block table.
package pbt_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [3:0] SockStream = 4'd1;
  localparam logic [3:0] SockDgram  = 4'd2;

  typedef enum logic [2:0] {
    FnCheck   = 3'd0,
    FnBlock   = 3'd1,
    FnUnblock = 3'd2,
    FnQuery   = 3'd3,
    FnReset   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StPerm    = 3'd1,
    StInval   = 3'd2,
    StNoent   = 3'd3,
    StFull    = 3'd4,
    StBlocked = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic        privileged;
    logic [7:0]  protocol;
    logic [3:0]  socket_type;
    logic [1:0]  direction;
    logic [15:0] port;
  } req_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [15:0] port;
    logic        dir;
    logic        is_udp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/port_block_table_with_hit_counts.sv
// Top level of the port block table with per-entry hit counters.
//
//   channel  dir  tdata                                           tuser
//   s_axis   in   protocol, socket_type, direction, port (32 b)   func, privileged
//   m_axis   out  status, hit_count (40 b)                        -
//
// Ops that search the table scan the memory one entry per cycle over its single
// read port, then pass a drain step before commit; other ops go from decode to commit.
// Reset clears all valid bits at once; no sweep.
// A result waits in the output register while the next word is accepted;
// a stalled output holds the sequencer in its commit step.
module port_block_table_with_hit_counts #(
  parameter int unsigned TABLE_ENTRIES = pbt_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // protocol, socket_type, direction, port, 2'b0
  input  logic [3:0]  s_axis_tuser,  // func, privileged
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status, hit_count, 5'b0
);
  import pbt_pkg::*;

  req_t        req;
  cmd_t        cmd;
  sts_t        sts;
  status_e     out_status;
  logic [31:0] out_hits;

  assign req.func        = s_axis_tuser[2:0];
  assign req.privileged  = s_axis_tuser[3];
  assign req.protocol    = s_axis_tdata[7:0];
  assign req.socket_type = s_axis_tdata[11:8];
  assign req.direction   = s_axis_tdata[13:12];
  assign req.port        = s_axis_tdata[29:14];

  pbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_hits_o   (out_hits)
  );

  assign m_axis_tdata = {5'b0, out_hits, out_status};

endmodule

>>> hdl/pbt_ctrl.sv
// Sequencer: accept, decode, table scan, drain, commit.
module pbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pbt_pkg::sts_t sts_i,
  output pbt_pkg::cmd_t cmd_o
);
  import pbt_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SDecode,
    SScan,
    SDrain,
    SCommit
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            state_q <= SDecode;
            ready_q <= 1'b0;
          end
        end
        SDecode: begin
          state_q <= sts_i.need_scan ? SScan : SCommit;
        end
        SScan: begin
          if (sts_i.scan_last) begin
            state_q <= SDrain;
          end
        end
        SDrain: begin
          state_q <= SCommit;
        end
        SCommit: begin
          if (sts_i.out_free) begin
            state_q <= SIdle;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= SIdle;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o    = ready_q;
  assign cmd_o.load    = ready_q & in_valid_i;
  assign cmd_o.scan    = (state_q == SScan);
  assign cmd_o.commit  = (state_q == SCommit) & sts_i.out_free;

endmodule

>>> hdl/pbt_dp.sv
// Datapath: request register, entry memory, scan compare, update and result register.
module pbt_dp #(
  parameter int unsigned TABLE_ENTRIES = pbt_pkg::TableEntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbt_pkg::req_t    req_i,
  input  pbt_pkg::cmd_t    cmd_i,
  output pbt_pkg::sts_t    sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pbt_pkg::status_e out_status_o,
  output logic [31:0]      out_hits_o
);
  import pbt_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  req_t            req_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  entry_t          mem_q [TABLE_ENTRIES];
  entry_t          rd_data_q;
  logic            rd_pend_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdxW-1:0] scan_idx_q;
  logic            found_q;
  logic [IdxW-1:0] match_idx_q;
  logic [31:0]     match_hits_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic            out_valid_q;
  status_e         out_status_q;
  logic [31:0]     out_hits_q;

  logic        key_udp;
  logic        args_ok;
  logic        stype_ok;
  logic        hit_match;
  logic        hit_free;
  logic [31:0] hits_inc;

  status_e         res_status;
  logic [31:0]     res_hits;
  logic            need_scan;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic            set_valid;
  logic            clr_one;
  logic            clr_all;

  assign stype_ok = (req_q.socket_type == SockStream) | (req_q.socket_type == SockDgram);
  assign args_ok  = ((req_q.protocol == ProtoTcp) | (req_q.protocol == ProtoUdp)) &
                    ~req_q.direction[1];
  assign key_udp  = (req_q.func == FnCheck) ? (req_q.socket_type == SockDgram)
                                            : (req_q.protocol == ProtoUdp);

  assign hit_match = rd_pend_q & valid_q[rd_idx_q] & (rd_data_q.is_udp == key_udp) &
                     ({1'b0, rd_data_q.dir} == req_q.direction) &
                     (rd_data_q.port == req_q.port);
  assign hit_free  = rd_pend_q & ~valid_q[rd_idx_q];
  assign hits_inc  = (&match_hits_q) ? match_hits_q : match_hits_q + 32'd1;

  always_comb begin
    res_status = StOk;
    res_hits   = '0;
    need_scan  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = match_idx_q;
    set_valid  = 1'b0;
    clr_one    = 1'b0;
    clr_all    = 1'b0;
    priority if (req_q.func == FnCheck) begin
      need_scan = stype_ok;
      if (stype_ok && found_q) begin
        res_status = StBlocked;
        wr_en      = 1'b1;
      end
    end else if (req_q.func > FnReset) begin
      res_status = StInval;
    end else if (!req_q.privileged) begin
      res_status = StPerm;
    end else if (req_q.func == FnReset) begin
      clr_all = 1'b1;
    end else if (!args_ok) begin
      res_status = StInval;
    end else begin
      need_scan = 1'b1;
      priority if (req_q.func == FnBlock) begin
        if (found_q) begin
          res_status = StInval;
        end else if (free_q) begin
          wr_en     = 1'b1;
          wr_addr   = free_idx_q;
          set_valid = 1'b1;
        end else begin
          res_status = StFull;
        end
      end else if (req_q.func == FnUnblock) begin
        if (found_q) begin
          clr_one = 1'b1;
        end else begin
          res_status = StNoent;
        end
      end else begin
        if (found_q) begin
          res_hits = match_hits_q;
        end else begin
          res_status = StNoent;
        end
      end
    end
  end

  // entry storage and data registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem_q[wr_addr] <= '{hits:   set_valid ? 32'd0 : hits_inc,
                          port:   req_q.port,
                          dir:    req_q.direction[0],
                          is_udp: key_udp};
    end
    if (cmd_i.scan) begin
      rd_data_q <= mem_q[scan_idx_q];
    end
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (hit_match && !found_q) begin
      match_idx_q  <= rd_idx_q;
      match_hits_q <= rd_data_q.hits;
    end
    if (hit_free && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_hits_q   <= res_hits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      scan_idx_q  <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan;
      rd_idx_q  <= scan_idx_q;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        free_q     <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (hit_match) begin
          found_q <= 1'b1;
        end
        if (hit_free) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (clr_all) begin
          valid_q <= '0;
        end else if (set_valid) begin
          valid_q[free_idx_q] <= 1'b1;
        end else if (clr_one) begin
          valid_q[match_idx_q] <= 1'b0;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.need_scan = need_scan;
  assign sts_o.scan_last = (scan_idx_q == LastIdx);
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_hits_o   = out_hits_q;

endmodule
